>>> hw/rtl/cksalu_pkg.sv
package cksalu_pkg;

	localparam int XLEN = 64;

	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_DIV = 3'd3;
	localparam logic [2:0] MODE_REM = 3'd4;

	localparam logic [1:0] FAULT_NONE = 2'd0;
	localparam logic [1:0] FAULT_OVF  = 2'd1;
	localparam logic [1:0] FAULT_DIV0 = 2'd2;

	// Everything an item carries alongside the divider datapath.
	typedef struct packed {
		logic [2:0]      mode;
		logic [1:0]      fault;
		logic [XLEN-1:0] res;
		logic            div_op;
		logic            qneg;
		logic            rneg;
	} side_t;

endpackage

>>> hw/rtl/cksalu_div_step.sv
module cksalu_div_step #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] rem,
	input  logic [W-1:0] dvd,
	input  logic [W-1:0] dvs,
	output logic [W-1:0] rem_q,
	output logic [W-1:0] dvd_q,
	output logic [W-1:0] dvs_q
);

	logic [W:0]   shifted;
	logic [W:0]   diff;
	logic         ge;

	// One restoring division step: bring in the next dividend bit and try to subtract.
	always_comb begin
		shifted = {rem, dvd[W-1]};
		diff    = shifted - {1'b0, dvs};
		ge      = ~diff[W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
			dvd_q <= {dvd[W-2:0], ge};
			dvs_q <= dvs;
		end
	end

endmodule

>>> hw/rtl/cksalu_mul.sv
module cksalu_mul #(
	parameter int W = 64
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [W-1:0]                ma,
	input  logic [W-1:0]                mb,
	input  logic                        neg,
	output logic [cksalu_pkg::XLEN-1:0] res_q,
	output logic [1:0]                  fault_q
);

	localparam int X = cksalu_pkg::XLEN;

	logic [X-1:0] xa, xb;
	logic [X-1:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic         neg_s1;
	logic [33:0]  mid;
	logic [X-1:0] lo_s2, hi_s2;
	logic         neg_s2;
	logic [X-1:0] limit;
	logic [X-1:0] mag_res;
	logic         ovf;

	assign xa = X'(ma);
	assign xb = X'(mb);

	// Four 32x32 partial products of the magnitudes.
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1  <= X'(xa[31:0]) * X'(xb[31:0]);
			lh_s1  <= X'(xa[31:0]) * X'(xb[63:32]);
			hl_s1  <= X'(xa[63:32]) * X'(xb[31:0]);
			hh_s1  <= X'(xa[63:32]) * X'(xb[63:32]);
			neg_s1 <= neg;
		end
	end

	assign mid = 34'(ll_s1[63:32]) + 34'(lh_s1[31:0]) + 34'(hl_s1[31:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s2  <= {mid[31:0], ll_s1[31:0]};
			hi_s2  <= hh_s1 + X'(lh_s1[63:32]) + X'(hl_s1[63:32]) + X'(mid[33:32]);
			neg_s2 <= neg_s1;
		end
	end

	always_comb begin
		limit   = (X'(1) << (W - 1)) - (neg_s2 ? X'(0) : X'(1));
		ovf     = (hi_s2 != '0) || (lo_s2 > limit);
		mag_res = neg_s2 ? (X'(0) - lo_s2) : lo_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q   <= ovf ? '0 : X'($signed(mag_res[W-1:0]));
			fault_q <= ovf ? cksalu_pkg::FAULT_OVF : cksalu_pkg::FAULT_NONE;
		end
	end

endmodule

>>> hw/rtl/checked_signed_integer_alu.sv
// Channel   Handshake              Payload
// request   req_valid/req_ready    mode, operand_a, operand_b
// response  rsp_valid/rsp_ready    result, fault
//
// Each item passes through the input stage, the divider stages and the response register;
// the depth is set by the divider, which retires one quotient bit per stage.
// A new item can be accepted every cycle while responses are taken, so the sustained rate is one item per cycle.
// Reset clears only the valid bits of the pipeline; payload registers are not reset.
// The whole pipeline moves together: when the response register holds an item that
// is not taken, every stage holds and req_ready drops, so nothing is lost or repeated.
module checked_signed_integer_alu #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [2:0]                        mode,
	input  logic signed [cksalu_pkg::XLEN-1:0] operand_a,
	input  logic signed [cksalu_pkg::XLEN-1:0] operand_b,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic signed [cksalu_pkg::XLEN-1:0] result,
	output logic [1:0]                        fault
);

	localparam int W = DATA_WIDTH;
	localparam int X = cksalu_pkg::XLEN;

	// The pipeline advances as a whole whenever the response register is free or its item is being taken.
	logic advance;
	assign advance   = ~rsp_valid | rsp_ready;
	assign req_ready = advance;

	// Input stage: operands are cut down to the working width here.
	logic         v_s0;
	logic [2:0]   mode_s0;
	logic [W-1:0] a_s0, b_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (advance) begin
			v_s0 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s0 <= mode;
			a_s0    <= operand_a[W-1:0];
			b_s0    <= operand_b[W-1:0];
		end
	end

	// Add, subtract and the special divide cases are settled right after the input stage.
	// Multiply and divide continue in their own pipelines.
	logic [W-1:0]      sum, diff, ma, mb;
	logic              a_neg, b_neg, add_ovf, sub_ovf;
	logic              b_zero, min_by_m1;
	cksalu_pkg::side_t side0;

	always_comb begin
		a_neg     = a_s0[W-1];
		b_neg     = b_s0[W-1];
		sum       = a_s0 + b_s0;
		diff      = a_s0 - b_s0;
		add_ovf   = (a_neg == b_neg) && (sum[W-1] != a_neg);
		sub_ovf   = (a_neg != b_neg) && (diff[W-1] != a_neg);
		ma        = a_neg ? (W'(0) - a_s0) : a_s0;
		mb        = b_neg ? (W'(0) - b_s0) : b_s0;
		b_zero    = (b_s0 == '0);
		min_by_m1 = (a_s0 == {1'b1, {(W-1){1'b0}}}) && (b_s0 == {W{1'b1}});

		side0        = '0;
		side0.mode   = mode_s0;
		side0.qneg   = a_neg ^ b_neg;
		side0.rneg   = a_neg;
		case (mode_s0)
			cksalu_pkg::MODE_ADD: begin
				side0.fault = add_ovf ? cksalu_pkg::FAULT_OVF : cksalu_pkg::FAULT_NONE;
				side0.res   = add_ovf ? '0 : X'($signed(sum));
			end
			cksalu_pkg::MODE_SUB: begin
				side0.fault = sub_ovf ? cksalu_pkg::FAULT_OVF : cksalu_pkg::FAULT_NONE;
				side0.res   = sub_ovf ? '0 : X'($signed(diff));
			end
			cksalu_pkg::MODE_DIV, cksalu_pkg::MODE_REM: begin
				if (b_zero) begin
					side0.fault = cksalu_pkg::FAULT_DIV0;
				end else if (min_by_m1) begin
					// The most negative value by minus one overflows a quotient,
					// while its remainder is simply zero.
					side0.fault = (mode_s0 == cksalu_pkg::MODE_DIV) ?
						cksalu_pkg::FAULT_OVF : cksalu_pkg::FAULT_NONE;
				end else begin
					side0.div_op = 1'b1;
				end
			end
			default: begin
				side0.fault = cksalu_pkg::FAULT_NONE;
			end
		endcase
	end

	// Multiplier: three stages, its result lines up with divider stage 3.
	logic [X-1:0] mul_res;
	logic [1:0]   mul_fault;

	cksalu_mul #(.W(W)) u_mul (
		.clk     (clk),
		.en      (advance),
		.ma      (ma),
		.mb      (mb),
		.neg     (a_neg ^ b_neg),
		.res_q   (mul_res),
		.fault_q (mul_fault)
	);

	// Divider: one restoring step per stage on the magnitudes.
	logic [W-1:0]      rem_w [0:W];
	logic [W-1:0]      dvd_w [0:W];
	logic [W-1:0]      dvs_w [0:W];
	cksalu_pkg::side_t side_s [0:W];
	logic              v_s [0:W];

	assign rem_w[0]  = '0;
	assign dvd_w[0]  = ma;
	assign dvs_w[0]  = mb;
	assign side_s[0] = side0;
	assign v_s[0]    = v_s0;

	for (genvar k = 1; k <= W; k++) begin : g_div
		cksalu_pkg::side_t side_in;

		cksalu_div_step #(.W(W)) u_step (
			.clk   (clk),
			.en    (advance),
			.rem   (rem_w[k-1]),
			.dvd   (dvd_w[k-1]),
			.dvs   (dvs_w[k-1]),
			.rem_q (rem_w[k]),
			.dvd_q (dvd_w[k]),
			.dvs_q (dvs_w[k])
		);

		if (k == 4) begin : g_merge
			// The multiplier output belongs to the item now held in stage 3.
			always_comb begin
				side_in = side_s[k-1];
				if (side_s[k-1].mode == cksalu_pkg::MODE_MUL) begin
					side_in.res   = mul_res;
					side_in.fault = mul_fault;
				end
			end
		end else begin : g_pass
			assign side_in = side_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (advance) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				side_s[k] <= side_in;
			end
		end
	end

	// Final sign fix-up of quotient or remainder, then the response register.
	logic [W-1:0] quo_fix, rem_fix;
	logic [X-1:0] res_next;

	always_comb begin
		quo_fix  = side_s[W].qneg ? (W'(0) - dvd_w[W]) : dvd_w[W];
		rem_fix  = side_s[W].rneg ? (W'(0) - rem_w[W]) : rem_w[W];
		res_next = side_s[W].res;
		if (side_s[W].div_op) begin
			res_next = (side_s[W].mode == cksalu_pkg::MODE_DIV) ?
				X'($signed(quo_fix)) : X'($signed(rem_fix));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (advance) begin
			rsp_valid <= v_s[W];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result <= res_next;
			fault  <= side_s[W].fault;
		end
	end

	// A flagged fault always comes with a zero result.
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (fault != cksalu_pkg::FAULT_NONE) |-> result == '0)
		else $error("fault reported with nonzero result");

	// The fault code never takes the unused encoding.
	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> fault != 2'd3)
		else $error("unused fault code");

	// A waiting result holds while the input side is blocked.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result) && !$past(req_ready))
		else $error("stalled result changed");

endmodule
